### rtl/core/lrast_pkg.sv
package lrast_pkg;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned M_TDATA_W = 32;
	localparam int unsigned PADDR_W = 3;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUM = 1'b1;

	localparam logic REG_ACTIVE_LEAVES = 1'b0;

endpackage

### rtl/core/lazy_range_add_range_sum_tree.sv
// Range-add / range-sum array over active_leaves signed 32-bit elements.
// Input stream s_*: tuser carries op (0 add delta over [range_lo, range_hi],
// 1 return the wrapped sum over that range). Ranges clip to the active
// elements; an empty range adds nothing or returns 0. Only a query gives a
// result item on m_*.
// The state lives in two Fenwick-tree memories (one for the linear term, one
// for the offset term), each entry read, modified and written back through
// the ST_RD and ST_WR states. An update walks upward from two positions; a
// query walks down from two prefix positions with a multiply-subtract after
// each. One item is in work at a time; s_tready is high only when the
// sequencer is idle, and it stays high while a finished result waits.
// A query result waits in the output register when m_tready is low; the
// sequencer holds until that register is free.
// Reset and any write of active_leaves start a clearing pass that zeroes
// both memories; no item is taken meanwhile. The APB register at address 0
// is active_leaves; only the low 11 bits of a write count: 0 reads back as 1
// and values above MAX_LEAVES as MAX_LEAVES.
module lazy_range_add_range_sum_tree #(
	parameter int unsigned MAX_LEAVES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lrast_pkg::S_TDATA_W-1:0]   s_tdata,  // range_lo, range_hi, delta, zero pad
	input  logic                              s_tuser,  // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lrast_pkg::M_TDATA_W-1:0]   m_tdata,  // range_sum
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lrast_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import lrast_pkg::*;

	localparam int unsigned AW    = $clog2(MAX_LEAVES + 1);
	localparam int unsigned IW    = AW + 1;
	localparam int unsigned DEPTH = MAX_LEAVES + 1;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_UMUL, ST_RD, ST_WR, ST_QMUL, ST_QSUB, ST_OUT
	} state_t;

	logic [DATA_W-1:0] lin_mem [DEPTH];
	logic [DATA_W-1:0] off_mem [DEPTH];

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [CNT_W-1:0]  active_q;
	logic              op_q;
	logic              phase_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [DATA_W-1:0] d_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     pidx_q;
	logic [DATA_W-1:0] v1_q;
	logic [DATA_W-1:0] v2_q;
	logic [DATA_W-1:0] acc1_q;
	logic [DATA_W-1:0] acc2_q;
	logic [DATA_W-1:0] pa_q;
	logic [DATA_W-1:0] prod_s1;
	logic [DATA_W-1:0] rd1_q;
	logic [DATA_W-1:0] rd2_q;
	logic [DATA_W-1:0] qres_q;
	logic [DATA_W-1:0] res_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]  in_lo;
	logic [IDX_W-1:0]  in_hi;
	logic [DATA_W-1:0] in_delta;
	logic [CNT_W-1:0]  top;
	logic [CNT_W-1:0]  hi_c;
	logic              empty;
	logic              cfg_wr;
	logic [CNT_W-1:0]  cfg_v;
	logic [IW-1:0]     lowbit;
	logic              idx_out;
	logic [CNT_W-1:0]  umul_op;
	logic [DATA_W-1:0] umul;
	logic [DATA_W-1:0] pref;
	logic              out_load;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [DATA_W-1:0] mem_wd1;
	logic [DATA_W-1:0] mem_wd2;

	assign in_lo    = s_tdata[IDX_W-1:0];
	assign in_hi    = s_tdata[2*IDX_W-1:IDX_W];
	assign in_delta = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
	assign top      = active_q - CNT_W'(1);
	assign hi_c     = (CNT_W'(in_hi) > top) ? top : CNT_W'(in_hi);
	assign empty    = CNT_W'(in_lo) > hi_c;

	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_LEAVES);
	always_comb begin
		cfg_v = pwdata[CNT_W-1:0];
		if (cfg_v == '0) begin
			cfg_v = CNT_W'(1);
		end
		if (32'(cfg_v) > 32'(MAX_LEAVES)) begin
			cfg_v = CNT_W'(MAX_LEAVES);
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACTIVE_LEAVES) ? 32'(active_q) : 32'd0;

	assign lowbit  = idx_q & (~idx_q + IW'(1));
	assign idx_out = (idx_q == '0) || (32'(idx_q) > 32'(MAX_LEAVES));
	assign umul_op = phase_q ? (hi_q + CNT_W'(1)) : lo_q;
	assign umul    = DATA_W'(d_q * 32'(umul_op));
	assign pref    = prod_s1 - acc2_q;

	assign out_load = (state_q == ST_OUT) && !cfg_wr && (!out_valid_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = idx_q[AW-1:0];
		mem_wd1 = rd1_q + v1_q;
		mem_wd2 = rd2_q + v2_q;
		if (state_q == ST_CLR) begin
			mem_we  = 1'b1;
			mem_wa  = clr_q;
			mem_wd1 = '0;
			mem_wd2 = '0;
		end else if (state_q == ST_WR && op_q == OP_ADD) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lin_mem[mem_wa] <= mem_wd1;
			off_mem[mem_wa] <= mem_wd2;
		end
		rd1_q <= lin_mem[idx_q[AW-1:0]];
		rd2_q <= off_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			active_q    <= CNT_W'(MAX_LEAVES);
			out_valid_q <= 1'b0;
			op_q        <= OP_ADD;
			phase_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				active_q <= cfg_v;
				clr_q    <= '0;
				state_q  <= ST_CLR;
			end else begin
				unique case (state_q)
					ST_CLR: begin
						clr_q <= clr_q + AW'(1);
						if (32'(clr_q) == 32'(MAX_LEAVES)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (s_tvalid) begin
							op_q    <= s_tuser;
							phase_q <= 1'b0;
							lo_q    <= CNT_W'(in_lo);
							hi_q    <= hi_c;
							d_q     <= in_delta;
							acc1_q  <= '0;
							acc2_q  <= '0;
							if (s_tuser == OP_ADD) begin
								idx_q <= IW'(in_lo) + IW'(1);
								v1_q  <= in_delta;
								if (!empty) begin
									state_q <= ST_UMUL;
								end
							end else if (empty) begin
								qres_q  <= '0;
								state_q <= ST_OUT;
							end else begin
								idx_q   <= IW'(hi_c) + IW'(1);
								pidx_q  <= IW'(hi_c) + IW'(1);
								state_q <= ST_RD;
							end
						end
					end
					ST_UMUL: begin
						v2_q    <= phase_q ? (DATA_W'(0) - umul) : umul;
						state_q <= ST_RD;
					end
					ST_RD: begin
						if (idx_out) begin
							if (op_q == OP_SUM) begin
								state_q <= ST_QMUL;
							end else if (!phase_q) begin
								phase_q <= 1'b1;
								idx_q   <= IW'(hi_q) + IW'(2);
								v1_q    <= DATA_W'(0) - d_q;
								state_q <= ST_UMUL;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_WR;
						end
					end
					ST_WR: begin
						if (op_q == OP_ADD) begin
							idx_q <= idx_q + lowbit;
						end else begin
							idx_q  <= idx_q - lowbit;
							acc1_q <= acc1_q + rd1_q;
							acc2_q <= acc2_q + rd2_q;
						end
						state_q <= ST_RD;
					end
					ST_QMUL: begin
						prod_s1 <= DATA_W'(acc1_q * 32'(pidx_q));
						state_q <= ST_QSUB;
					end
					ST_QSUB: begin
						if (!phase_q) begin
							pa_q    <= pref;
							phase_q <= 1'b1;
							idx_q   <= IW'(lo_q);
							pidx_q  <= IW'(lo_q);
							acc1_q  <= '0;
							acc2_q  <= '0;
							state_q <= ST_RD;
						end else begin
							qres_q  <= pa_q - pref;
							state_q <= ST_OUT;
						end
					end
					ST_OUT: begin
						if (out_load) begin
							res_q   <= qres_q;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

### dv/lrast_checker.sv
module lrast_checker #(
	parameter int unsigned MAX_LEAVES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [lrast_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [lrast_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [lrast_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output int                              fail_count,
	output int                              sums_waiting,
	output int                              adds_seen,
	output int                              sums_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import lrast_pkg::*;

	logic [DATA_W-1:0] elem [MAX_LEAVES];
	logic [DATA_W-1:0] sum_q [$];
	int unsigned leaves;

	function automatic logic [DATA_W-1:0] range_total(int unsigned lo, int unsigned hi);
		logic [DATA_W-1:0] acc;
		acc = '0;
		for (int unsigned i = lo; i <= hi && i < leaves; i++)
			acc += elem[i];
		return acc;
	endfunction

	task automatic range_add(int unsigned lo, int unsigned hi, logic [DATA_W-1:0] d);
		for (int unsigned i = lo; i <= hi && i < leaves; i++)
			elem[i] += d;
	endtask

	assign sums_waiting = sum_q.size();

	always @(posedge clk or negedge arst_n) begin
		int unsigned lo, hi, v;
		logic [DATA_W-1:0] want;
		if (!arst_n) begin
			foreach (elem[i]) elem[i] = '0;
			sum_q.delete();
			leaves = MAX_LEAVES;
			fail_count <= 0;
			adds_seen <= 0;
			sums_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_LEAVES) begin
				v = pwdata & 32'h7FF;
				if (v < 1) v = 1;
				if (v > MAX_LEAVES) v = MAX_LEAVES;
				leaves = v;
				foreach (elem[i]) elem[i] = '0;
			end
			if (m_tvalid && m_tready) begin
				if (sum_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result item: %h", m_tdata);
				end else begin
					want = sum_q.pop_front();
					if (want !== m_tdata) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("range_sum mismatch: exp %h got %h", want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				lo = s_tdata[IDX_W-1:0];
				hi = s_tdata[2*IDX_W-1:IDX_W];
				if (s_tuser == OP_SUM) begin
					sum_q.push_back(range_total(lo, hi));
					sums_seen <= sums_seen + 1;
				end else begin
					range_add(lo, hi, s_tdata[2*IDX_W+DATA_W-1:2*IDX_W]);
					adds_seen <= adds_seen + 1;
				end
			end
		end
	end
endmodule

### dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lrast_pkg::*;

	localparam int unsigned LEAVES_MAX = 1024;
	localparam int STALL_LIMIT = 6000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	int fail_count, sums_waiting, adds_seen, sums_seen;
	int idle_cycles = 0;
	bit no_gaps = 0;
	bit hold_req = 0;
	int unsigned leaves = LEAVES_MAX;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	lazy_range_add_range_sum_tree #(.MAX_LEAVES(LEAVES_MAX)) u_dut (.*);

	lrast_checker #(.MAX_LEAVES(LEAVES_MAX)) u_chk (.*);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side
	initial begin
		int stall;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_item(logic op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
			logic [DATA_W-1:0] d);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {4'b0, d, hi, lo};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sums_waiting != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] val);
		drain();
		psel <= 1;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == PADDR_W'(4 * REG_ACTIVE_LEAVES)) begin
			leaves = val & 32'h7FF;
			if (leaves < 1) leaves = 1;
			if (leaves > LEAVES_MAX) leaves = LEAVES_MAX;
		end
	endtask

	task automatic random_items(int n);
		int unsigned lo, hi, t;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				lo = $urandom_range(0, leaves - 1);
				hi = $urandom_range(lo, leaves - 1);
				if ($urandom_range(0, 3) == 0) hi = lo;
			end else begin
				lo = $urandom_range(0, 1023);
				hi = $urandom_range(0, 1023);
			end
			t = $urandom_range(0, 3);
			send_item(t == 0 ? OP_SUM : (t == 1 ? OP_ADD : logic'($urandom_range(0, 1))),
				lo, hi, $urandom());
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes and empty ranges
		send_item(OP_SUM, 0, 1023, 0);
		send_item(OP_ADD, 0, 1023, 32'h7FFF_FFFF);
		send_item(OP_ADD, 1023, 1023, 32'h8000_0000);
		send_item(OP_ADD, 600, 5, 32'hFFFF_FFFF);
		send_item(OP_SUM, 0, 1023, 32'hFFFF_FFFF);
		send_item(OP_SUM, 1023, 0, 0);
		send_item(OP_SUM, 0, 0, 0);
		send_item(OP_SUM, 1023, 1023, 0);
		send_item(OP_ADD, 10, 20, 32'hFFFF_FFFF);
		send_item(OP_SUM, 5, 25, 0);
		send_item(OP_ADD, 511, 512, 32'h0000_0001);
		send_item(OP_SUM, 500, 520, 0);
		send_item(OP_SUM, 512, 1023, 0);
		random_items(200);

		write_reg(PADDR_W'(4 * REG_ACTIVE_LEAVES), 1);
		send_item(OP_ADD, 0, 1023, 32'h1234_5678);
		send_item(OP_SUM, 0, 1023, 0);
		send_item(OP_SUM, 1, 1023, 0);
		send_item(OP_ADD, 1, 5, 32'h1);
		send_item(OP_SUM, 0, 0, 0);
		random_items(150);

		write_reg(PADDR_W'(4 * REG_ACTIVE_LEAVES), 0);
		random_items(100);

		write_reg(PADDR_W'(4 * REG_ACTIVE_LEAVES), 32'hFFFF_F7FF);
		send_item(OP_SUM, 0, 1023, 0);
		hold_req = 1;
		random_items(250);

		write_reg(PADDR_W'(4 * REG_ACTIVE_LEAVES), 5);
		send_item(OP_ADD, 3, 1023, 32'h8000_0000);
		send_item(OP_SUM, 4, 900, 0);
		send_item(OP_SUM, 5, 9, 0);
		random_items(200);

		// write to an unmapped address must not touch the array
		write_reg(PADDR_W'(4), 3);
		random_items(100);

		write_reg(PADDR_W'(4 * REG_ACTIVE_LEAVES), 300);
		no_gaps = 1;
		random_items(200);
		no_gaps = 0;
		random_items(100);

		write_reg(PADDR_W'(4 * REG_ACTIVE_LEAVES), 1024);
		random_items(200);
		hold_req = 1;
		random_items(100);

		drain();
		$display("covered %0d range adds and %0d range sums over sizes 1, 5, 300 and 1024",
			adds_seen, sums_seen);
		$display("with random gaps, gap-free stretches and long result back-pressure");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

### sim.f
rtl/core/lrast_pkg.sv
rtl/core/lazy_range_add_range_sum_tree.sv
dv/lrast_checker.sv
dv/tb.sv
